@@ src/kds_pkg.sv @@
// ----------------------------------------------------------------------------
// kds_pkg
// shared types, constants and dominance functions of the skyline filter
// ----------------------------------------------------------------------------
package kds_pkg;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = 64;
  localparam int COORD_W     = 32;
  localparam int ID_W        = 16;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int KEY_W       = ID_W + IDX_W;
  localparam int REG_W       = 4;

  // result status codes
  localparam logic [2:0] ST_CAND     = 3'd0;
  localparam logic [2:0] ST_OTHER    = 3'd1;
  localparam logic [2:0] ST_REJECT   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_READOUT  = 3'd4;

  // register indexes
  localparam logic REG_K_NEEDED  = 1'b0;
  localparam logic REG_DIMS_USED = 1'b1;

  typedef logic [MAX_DIM-1:0][COORD_W-1:0] coords_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    coords_t         coords;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_O_RD, OP_O_EV, OP_C_INIT, OP_C_RD, OP_C_EV,
    OP_M_INIT, OP_M_RD, OP_M_EV, OP_APPEND, OP_R_INIT, OP_R_SCAN,
    OP_R_RD, OP_R_EV, OP_R_PICK, OP_SEND
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic r_end;
    logic rej;
    logic ovf;
    logic nc_zero;
    logic res_last;
    logic out_free;
    logic ro;
  } stat_t;

  function automatic logic [REG_W-1:0] sat_dims(logic [REG_W-1:0] dims);
    sat_dims = (dims > REG_W'(MAX_DIM)) ? REG_W'(MAX_DIM) : dims;
  endfunction

  // a dominates b: nowhere worse, strictly better somewhere
  function automatic logic dominates(coords_t a, coords_t b, logic [REG_W-1:0] dims);
    logic [REG_W-1:0] d;
    logic lt;
    logic gt;
    d  = sat_dims(dims);
    lt = 1'b0;
    gt = 1'b0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (REG_W'(i) < d) begin
        if ($signed(a[i]) < $signed(b[i])) lt = 1'b1;
        if ($signed(a[i]) > $signed(b[i])) gt = 1'b1;
      end
    end
    dominates = lt & ~gt;
  endfunction

  // a k-dominates b: strictly better somewhere, not worse in at least k dims
  function automatic logic k_dominates(coords_t a, coords_t b, logic [REG_W-1:0] dims,
                                       logic [REG_W-1:0] k);
    logic [REG_W-1:0] d;
    logic [REG_W-1:0] cnt;
    logic lt;
    d   = sat_dims(dims);
    cnt = '0;
    lt  = 1'b0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (REG_W'(i) < d) begin
        if ($signed(a[i]) < $signed(b[i])) lt = 1'b1;
        if ($signed(a[i]) <= $signed(b[i])) cnt = cnt + 1'b1;
      end
    end
    k_dominates = lt & (cnt >= k);
  endfunction

endpackage

@@ src/k_dominant_skyline_filter.sv @@
// ----------------------------------------------------------------------------
// k_dominant_skyline_filter
// one-pass k-dominant skyline filter with candidate and other-point stores
// ----------------------------------------------------------------------------
//  channel | ports    | content
//  --------+----------+---------------------------------------------------
//  input   | in_      | tuser: cmd; tdata: point_id, coord_0..coord_7
//  result  | out_     | tuser: status; tdata: out_id, valid_entry; tlast
//  config  | cfg_     | APB, k_needed at 0x0, dims_used at 0x4
//
//  one item at a time; each store has one write and one registered read port
//  push: a rejection skips both candidate walks, an overflow skips the second
//  readout: one full scan of the candidate store for each candidate id given
//  reset: synchronous, active low; stores are empty after it, no clearing pass
//  a stalled result holds in the output register and the sequencer waits
// ----------------------------------------------------------------------------
module k_dominant_skyline_filter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [271:0] in_tdata,   // point_id[15:0], coord_0..coord_7 32 bits each
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // out_id[15:0], valid_entry[16], zero pad
  output logic [2:0]   out_tuser,  // status
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [kds_pkg::REG_W-1:0] k_needed_r, dims_used_r;
  logic                      cfg_wr;
  kds_pkg::cmd_t             cmd;
  kds_pkg::stat_t            stat;

  // register file, one transfer per access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_needed_r  <= kds_pkg::REG_W'(3);
      dims_used_r <= kds_pkg::REG_W'(4);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == kds_pkg::REG_K_NEEDED) begin
        k_needed_r <= cfg_pwdata[kds_pkg::REG_W-1:0];
      end else begin
        dims_used_r <= cfg_pwdata[kds_pkg::REG_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == kds_pkg::REG_DIMS_USED) begin
      cfg_prdata = {28'd0, dims_used_r};
    end else begin
      cfg_prdata = {28'd0, k_needed_r};
    end
  end

  // sequencer
  kds_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .stat, .cmd
  );

  // stores, comparators and result register
  kds_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_tuser, .in_tdata,
    .k_needed(k_needed_r), .dims_used(dims_used_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule

@@ src/kds_ram.sv @@
// ----------------------------------------------------------------------------
// kds_ram
// one store of points, one write and one registered read port
// ----------------------------------------------------------------------------
module kds_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [kds_pkg::IDX_W-1:0] waddr,
  input  kds_pkg::entry_t          wdata,
  input  logic [kds_pkg::IDX_W-1:0] raddr,
  output kds_pkg::entry_t          rdata
);

  kds_pkg::entry_t mem [kds_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/kds_datapath.sv @@
// ----------------------------------------------------------------------------
// kds_datapath
// point register, store walks, compaction, readout ordering, result register
// ----------------------------------------------------------------------------
module kds_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kds_pkg::cmd_t                   cmd,
  output kds_pkg::stat_t                  stat,
  input  logic                            in_tuser,
  input  logic [271:0]                    in_tdata,
  input  logic [kds_pkg::REG_W-1:0]       k_needed,
  input  logic [kds_pkg::REG_W-1:0]       dims_used,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,
  output logic [2:0]                      out_tuser,
  output logic                            out_tlast
);

  localparam int IW = kds_pkg::IDX_W;
  localparam int CW = kds_pkg::CNT_W;

  kds_pkg::entry_t pt_r, pt_nxt;
  logic            ro_r, ro_nxt;
  logic [CW-1:0]   no_r, no_nxt, nc_r, nc_nxt;
  logic [CW-1:0]   rd_r, rd_nxt, wr_r, wr_nxt;
  logic [CW-1:0]   moves_r, moves_nxt, em_r, em_nxt;
  logic            rej_r, rej_nxt, joins_r, joins_nxt;
  logic [kds_pkg::KEY_W-1:0] last_key_r, last_key_nxt, best_key_r, best_key_nxt;
  logic            have_r, have_nxt, found_r, found_nxt;
  logic [2:0]      res_st_r, res_st_nxt;
  logic [kds_pkg::ID_W-1:0] res_id_r, res_id_nxt;
  logic            res_ve_r, res_ve_nxt, res_last_r, res_last_nxt;
  logic            ov_r, ov_nxt;
  logic [2:0]      ost_r;
  logic [kds_pkg::ID_W-1:0] oid_r;
  logic            ove_r, olast_r;

  logic            o_we, c_we;
  logic [IW-1:0]   o_waddr, c_waddr;
  kds_pkg::entry_t o_wdata, c_wdata, o_rdata, c_rdata;
  kds_pkg::entry_t e;
  logic [kds_pkg::KEY_W-1:0] key;
  logic [CW:0]     o_need, c_need;
  logic            out_free;

  kds_ram u_other (.clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
                   .raddr(rd_r[IW-1:0]), .rdata(o_rdata));
  kds_ram u_cand  (.clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
                   .raddr(rd_r[IW-1:0]), .rdata(c_rdata));

  assign e        = (cmd.op == kds_pkg::OP_O_EV) ? o_rdata : c_rdata;
  assign key      = {c_rdata.id, rd_r[IW-1:0]};
  assign out_free = ~ov_r | out_tready;

  // other set grows by moves plus the point when it is k-dominated
  assign o_need = (CW+1)'(no_r) + (CW+1)'(moves_r) + (joins_r ? '0 : (CW+1)'(1));
  assign c_need = (CW+1)'(nc_r) - (CW+1)'(moves_r) + (CW+1)'(1);

  always_comb begin
    stat.r_end    = (cmd.op == kds_pkg::OP_O_RD) ? (rd_r == no_r) : (rd_r == nc_r);
    stat.rej      = rej_r;
    stat.ovf      = (o_need > (CW+1)'(kds_pkg::STORE_DEPTH)) |
                    (joins_r & (c_need > (CW+1)'(kds_pkg::STORE_DEPTH)));
    stat.nc_zero  = (nc_r == '0);
    stat.res_last = res_last_r;
    stat.out_free = out_free;
    stat.ro       = ro_r;
  end

  always_comb begin
    pt_nxt = pt_r;  ro_nxt = ro_r;  no_nxt = no_r;  nc_nxt = nc_r;
    rd_nxt = rd_r;  wr_nxt = wr_r;  moves_nxt = moves_r;  em_nxt = em_r;
    rej_nxt = rej_r;  joins_nxt = joins_r;
    last_key_nxt = last_key_r;  best_key_nxt = best_key_r;
    have_nxt = have_r;  found_nxt = found_r;
    res_st_nxt = res_st_r;  res_id_nxt = res_id_r;
    res_ve_nxt = res_ve_r;  res_last_nxt = res_last_r;
    o_we = 1'b0;  o_waddr = wr_r[IW-1:0];  o_wdata = e;
    c_we = 1'b0;  c_waddr = wr_r[IW-1:0];  c_wdata = e;
    case (cmd.op)
      kds_pkg::OP_LOAD: begin
        pt_nxt.id     = in_tdata[15:0];
        pt_nxt.coords = in_tdata[271:16];
        ro_nxt        = in_tuser;
        rd_nxt        = '0;
        wr_nxt        = '0;
        rej_nxt       = 1'b0;
        res_id_nxt    = in_tdata[15:0];
        res_ve_nxt    = 1'b0;
        res_last_nxt  = 1'b1;
      end
      kds_pkg::OP_O_RD: begin
        if (stat.r_end) begin
          no_nxt = wr_r;
          if (rej_r) res_st_nxt = kds_pkg::ST_REJECT;
        end
      end
      kds_pkg::OP_O_EV: begin
        // after a rejection the tail only shifts down over the gaps
        if (rej_r || !kds_pkg::dominates(pt_r.coords, e.coords, dims_used)) begin
          if (!rej_r && kds_pkg::dominates(e.coords, pt_r.coords, dims_used)) begin
            rej_nxt = 1'b1;
          end
          o_we   = 1'b1;
          wr_nxt = wr_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
      end
      kds_pkg::OP_C_INIT: begin
        rd_nxt    = '0;
        joins_nxt = 1'b1;
        moves_nxt = '0;
      end
      kds_pkg::OP_C_RD: begin
        if (stat.r_end && stat.ovf) res_st_nxt = kds_pkg::ST_OVERFLOW;
      end
      kds_pkg::OP_C_EV: begin
        if (kds_pkg::k_dominates(e.coords, pt_r.coords, dims_used, k_needed)) begin
          joins_nxt = 1'b0;
        end
        if (kds_pkg::k_dominates(pt_r.coords, e.coords, dims_used, k_needed)) begin
          moves_nxt = moves_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
      end
      kds_pkg::OP_M_INIT: begin
        rd_nxt = '0;
        wr_nxt = '0;
      end
      kds_pkg::OP_M_EV: begin
        if (kds_pkg::k_dominates(pt_r.coords, e.coords, dims_used, k_needed)) begin
          o_we    = 1'b1;
          o_waddr = no_r[IW-1:0];
          no_nxt  = no_r + 1'b1;
        end else begin
          c_we   = 1'b1;
          wr_nxt = wr_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
      end
      kds_pkg::OP_APPEND: begin
        if (joins_r) begin
          c_we       = 1'b1;
          c_wdata    = pt_r;
          nc_nxt     = wr_r + 1'b1;
          res_st_nxt = kds_pkg::ST_CAND;
        end else begin
          o_we       = 1'b1;
          o_waddr    = no_r[IW-1:0];
          o_wdata    = pt_r;
          no_nxt     = no_r + 1'b1;
          nc_nxt     = wr_r;
          res_st_nxt = kds_pkg::ST_OTHER;
        end
      end
      kds_pkg::OP_R_INIT: begin
        em_nxt   = '0;
        have_nxt = 1'b0;
        if (nc_r == '0) begin
          res_st_nxt   = kds_pkg::ST_READOUT;
          res_id_nxt   = '0;
          res_ve_nxt   = 1'b0;
          res_last_nxt = 1'b1;
        end
      end
      kds_pkg::OP_R_SCAN: begin
        rd_nxt    = '0;
        found_nxt = 1'b0;
      end
      kds_pkg::OP_R_EV: begin
        // smallest (id, slot) above the one given last keeps equal ids in order
        if ((!have_r || key > last_key_r) && (!found_r || key < best_key_r)) begin
          best_key_nxt = key;
          found_nxt    = 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
      end
      kds_pkg::OP_R_PICK: begin
        res_st_nxt   = kds_pkg::ST_READOUT;
        res_id_nxt   = best_key_r[kds_pkg::KEY_W-1:IW];
        res_ve_nxt   = 1'b1;
        res_last_nxt = (CW'(em_r + 1'b1) == nc_r);
        last_key_nxt = best_key_r;
        have_nxt     = 1'b1;
        em_nxt       = em_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.op == kds_pkg::OP_SEND && out_free) ov_nxt = 1'b1;
    else if (out_tready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_r <= '0;
      nc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      no_r <= no_nxt;
      nc_r <= nc_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;  ro_r <= ro_nxt;  rd_r <= rd_nxt;  wr_r <= wr_nxt;
    moves_r <= moves_nxt;  em_r <= em_nxt;  rej_r <= rej_nxt;  joins_r <= joins_nxt;
    last_key_r <= last_key_nxt;  best_key_r <= best_key_nxt;
    have_r <= have_nxt;  found_r <= found_nxt;
    res_st_r <= res_st_nxt;  res_id_r <= res_id_nxt;
    res_ve_r <= res_ve_nxt;  res_last_r <= res_last_nxt;
    if (cmd.op == kds_pkg::OP_SEND && out_free) begin
      ost_r   <= res_st_r;
      oid_r   <= res_id_r;
      ove_r   <= res_ve_r;
      olast_r <= res_last_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {7'd0, ove_r, oid_r};

endmodule

@@ src/kds_ctrl.sv @@
// ----------------------------------------------------------------------------
// kds_ctrl
// sequencer of push phases and readout scans
// ----------------------------------------------------------------------------
module kds_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  kds_pkg::stat_t stat,
  output kds_pkg::cmd_t  cmd
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_DECODE = 17'b00000000000000010,
    S_O_RD   = 17'b00000000000000100,
    S_O_EV   = 17'b00000000000001000,
    S_C_INIT = 17'b00000000000010000,
    S_C_RD   = 17'b00000000000100000,
    S_C_EV   = 17'b00000000001000000,
    S_M_INIT = 17'b00000000010000000,
    S_M_RD   = 17'b00000000100000000,
    S_M_EV   = 17'b00000001000000000,
    S_APPEND = 17'b00000010000000000,
    S_R_INIT = 17'b00000100000000000,
    S_R_SCAN = 17'b00001000000000000,
    S_R_RD   = 17'b00010000000000000,
    S_R_EV   = 17'b00100000000000000,
    S_R_PICK = 17'b01000000000000000,
    S_SEND   = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = kds_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = kds_pkg::OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: state_nxt = stat.ro ? S_R_INIT : S_O_RD;
      S_O_RD: begin
        cmd.op = kds_pkg::OP_O_RD;
        if (stat.r_end) state_nxt = stat.rej ? S_SEND : S_C_INIT;
        else            state_nxt = S_O_EV;
      end
      S_O_EV: begin
        cmd.op    = kds_pkg::OP_O_EV;
        state_nxt = S_O_RD;
      end
      S_C_INIT: begin
        cmd.op    = kds_pkg::OP_C_INIT;
        state_nxt = S_C_RD;
      end
      S_C_RD: begin
        cmd.op = kds_pkg::OP_C_RD;
        if (stat.r_end) state_nxt = stat.ovf ? S_SEND : S_M_INIT;
        else            state_nxt = S_C_EV;
      end
      S_C_EV: begin
        cmd.op    = kds_pkg::OP_C_EV;
        state_nxt = S_C_RD;
      end
      S_M_INIT: begin
        cmd.op    = kds_pkg::OP_M_INIT;
        state_nxt = S_M_RD;
      end
      S_M_RD: begin
        cmd.op    = kds_pkg::OP_M_RD;
        state_nxt = stat.r_end ? S_APPEND : S_M_EV;
      end
      S_M_EV: begin
        cmd.op    = kds_pkg::OP_M_EV;
        state_nxt = S_M_RD;
      end
      S_APPEND: begin
        cmd.op    = kds_pkg::OP_APPEND;
        state_nxt = S_SEND;
      end
      S_R_INIT: begin
        cmd.op    = kds_pkg::OP_R_INIT;
        state_nxt = stat.nc_zero ? S_SEND : S_R_SCAN;
      end
      S_R_SCAN: begin
        cmd.op    = kds_pkg::OP_R_SCAN;
        state_nxt = S_R_RD;
      end
      S_R_RD: begin
        cmd.op    = kds_pkg::OP_R_RD;
        state_nxt = stat.r_end ? S_R_PICK : S_R_EV;
      end
      S_R_EV: begin
        cmd.op    = kds_pkg::OP_R_EV;
        state_nxt = S_R_RD;
      end
      S_R_PICK: begin
        cmd.op    = kds_pkg::OP_R_PICK;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        cmd.op = kds_pkg::OP_SEND;
        if (stat.out_free) state_nxt = stat.res_last ? S_IDLE : S_R_SCAN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ verif/k_dominant_skyline_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_dominant_skyline_filter_test
// self-checking bench: streams points and readout commands through the filter
// under several register settings, predicts every result from its own copy
// of both point stores and checks each result transfer field by field
// ----------------------------------------------------------------------------
module k_dominant_skyline_filter_test;

  localparam int RESULT_CAP = 64;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int LONG_HOLD = 600;

  typedef struct {
    logic                     cmd;
    logic [kds_pkg::ID_W-1:0] id;
    kds_pkg::coords_t         coords;
  } point_item_t;

  typedef struct {
    logic [2:0]               status;
    logic [kds_pkg::ID_W-1:0] id;
    logic                     valid_entry;
    logic                     last;
  } filter_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [271:0] in_tdata;   // point_id[15:0], coord_0..coord_7 32 bits each
  logic         in_tuser;   // cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;  // out_id[15:0], valid_entry[16], zero pad
  logic [2:0]   out_tuser;  // status
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  k_dominant_skyline_filter dut (.*);

  // predictor state: the two compacted stores and the register copies
  kds_pkg::entry_t cand_store[$];
  kds_pkg::entry_t other_store[$];
  logic [3:0]     k_cfg;
  logic [3:0]     dims_cfg;

  point_item_t    pending_points[$];
  filter_result_t expected_results[$];
  int             fail_count = 0;
  int             results_seen = 0;
  longint         cycle_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // dominance as the filter defines it; dims above 8 saturate
  // ---------------------------------------------------------------------------
  function automatic int active_dims();
    return (dims_cfg > 4'd8) ? 8 : int'(dims_cfg);
  endfunction

  function automatic bit beats(kds_pkg::coords_t a, kds_pkg::coords_t b);
    bit better;
    better = 0;
    for (int i = 0; i < active_dims(); i++) begin
      if ($signed(a[i]) > $signed(b[i])) return 0;
      if ($signed(a[i]) < $signed(b[i])) better = 1;
    end
    return better;
  endfunction

  function automatic bit k_beats(kds_pkg::coords_t a, kds_pkg::coords_t b);
    bit better;
    int not_worse;
    better = 0;
    not_worse = 0;
    for (int i = 0; i < active_dims(); i++) begin
      if ($signed(a[i]) < $signed(b[i])) better = 1;
      if ($signed(a[i]) <= $signed(b[i])) not_worse++;
    end
    return better && (not_worse >= int'(k_cfg));
  endfunction

  function automatic filter_result_t push_result(logic [2:0] st,
                                                 logic [kds_pkg::ID_W-1:0] id);
    filter_result_t r;
    r.status = st;
    r.id = id;
    r.valid_entry = 1'b0;
    r.last = 1'b1;
    return r;
  endfunction

  // updates both stores for one accepted transfer and queues its results
  task automatic apply_to_skyline(point_item_t it);
    kds_pkg::entry_t pt;
    kds_pkg::entry_t kept[$];
    logic [kds_pkg::ID_W-1:0] ids[$];
    filter_result_t r;
    int i;
    int moves;
    int shown;
    bit joins;
    if (it.cmd) begin
      if (cand_store.size() == 0) begin
        r.status = kds_pkg::ST_READOUT;
        r.id = '0;
        r.valid_entry = 1'b0;
        r.last = 1'b1;
        expected_results = {expected_results, r};
      end else begin
        foreach (cand_store[j]) ids = {ids, cand_store[j].id};
        ids.sort();
        shown = (ids.size() > RESULT_CAP) ? RESULT_CAP : ids.size();
        for (int j = 0; j < shown; j++) begin
          r.status = kds_pkg::ST_READOUT;
          r.id = ids[j];
          r.valid_entry = 1'b1;
          r.last = (j == shown - 1);
          expected_results = {expected_results, r};
        end
      end
      return;
    end
    pt.id = it.id;
    pt.coords = it.coords;
    // other set: drop what the point dominates, stop at the first that beats it
    i = 0;
    while (i < other_store.size()) begin
      if (beats(pt.coords, other_store[i].coords)) begin
        other_store.delete(i);
      end else if (beats(other_store[i].coords, pt.coords)) begin
        expected_results = {expected_results, push_result(kds_pkg::ST_REJECT, it.id)};
        return;
      end else begin
        i++;
      end
    end
    joins = 1;
    moves = 0;
    foreach (cand_store[j]) begin
      if (k_beats(cand_store[j].coords, pt.coords)) joins = 0;
      if (k_beats(pt.coords, cand_store[j].coords)) moves++;
    end
    if (other_store.size() + moves + (joins ? 0 : 1) > kds_pkg::STORE_DEPTH ||
        (joins && cand_store.size() - moves + 1 > kds_pkg::STORE_DEPTH)) begin
      expected_results = {expected_results, push_result(kds_pkg::ST_OVERFLOW, it.id)};
      return;
    end
    foreach (cand_store[j]) begin
      if (k_beats(pt.coords, cand_store[j].coords)) other_store = {other_store, cand_store[j]};
      else kept = {kept, cand_store[j]};
    end
    cand_store = kept;
    if (joins) begin
      cand_store = {cand_store, pt};
      expected_results = {expected_results, push_result(kds_pkg::ST_CAND, it.id)};
    end else begin
      other_store = {other_store, pt};
      expected_results = {expected_results, push_result(kds_pkg::ST_OTHER, it.id)};
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of transfers with random gaps
  // ---------------------------------------------------------------------------
  point_item_t cur_point;
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) apply_to_skyline(cur_point);
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        cur_point = pending_points.pop_front();
        in_tdata  <= {cur_point.coords, cur_point.id};
        in_tuser  <= cur_point.cmd;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          // some bursts run back to back with no gap at all
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern plus one long hold-off to back up the input side
  // ---------------------------------------------------------------------------
  int  hold_left;
  bit  hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 30) begin
      hold_done  <= 1'b1;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (cycle_count[10]) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    filter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d id %0h",
               out_tuser, out_tdata[15:0]);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          fail_count++;
        end
        if (out_tdata[15:0] !== want.id) begin
          $error("out_id: expected %0h, actual %0h", want.id, out_tdata[15:0]);
          fail_count++;
        end
        if (out_tdata[16] !== want.valid_entry) begin
          $error("valid_entry: expected %0b, actual %0b", want.valid_entry, out_tdata[16]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (pending_points.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == kds_pkg::REG_K_NEEDED) k_cfg = value[3:0];
    else dims_cfg = value[3:0];
  endtask

  task automatic set_regs(logic [3:0] k, logic [3:0] dims);
    wait_idle();
    write_reg(kds_pkg::REG_K_NEEDED, {$urandom} & 32'hFFFF_FFF0 | k);
    write_reg(kds_pkg::REG_DIMS_USED, {$urandom} & 32'hFFFF_FFF0 | dims);
  endtask

  task automatic queue_push(logic [kds_pkg::ID_W-1:0] id, kds_pkg::coords_t c);
    point_item_t it;
    it.cmd = 1'b0;
    it.id = id;
    it.coords = c;
    pending_points = {pending_points, it};
  endtask

  task automatic queue_readout();
    point_item_t it;
    it.cmd = 1'b1;
    it.id = kds_pkg::ID_W'($urandom);
    for (int i = 0; i < kds_pkg::MAX_DIM; i++) it.coords[i] = 32'($urandom);
    pending_points = {pending_points, it};
  endtask

  // mostly narrow ranges so ties and dominance are frequent, some full range
  task automatic queue_random(int count, int readout_pct);
    kds_pkg::coords_t c;
    int span;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < readout_pct) begin
        queue_readout();
      end else begin
        span = $urandom_range(0, 9);
        for (int i = 0; i < kds_pkg::MAX_DIM; i++)
          c[i] = (span == 0) ? 32'($urandom) : 32'($signed($urandom_range(0, 2 * span)) - span);
        queue_push(kds_pkg::ID_W'($urandom), c);
      end
    end
  endtask

  function automatic kds_pkg::coords_t flat(logic [31:0] v);
    kds_pkg::coords_t c;
    for (int i = 0; i < kds_pkg::MAX_DIM; i++) c[i] = v;
    return c;
  endfunction

  initial begin
    kds_pkg::coords_t c;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    k_cfg       = 4'd3;
    dims_cfg    = 4'd4;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty readout, coordinate extremes, ties, rejection, moves
    queue_readout();
    queue_push(16'hFFFF, flat(32'h7FFF_FFFF));
    queue_push(16'h0000, flat(32'h8000_0000));
    queue_push(16'h0001, flat(32'h8000_0000));
    c = flat(32'h8000_0000);
    c[0] = 32'h7FFF_FFFF;
    queue_push(16'h0002, c);
    queue_push(16'h0003, flat(32'd5));
    c = flat(32'd5);
    c[3] = 32'd6;
    queue_push(16'h0004, c);
    c = flat(32'd5);
    c[0] = 32'd6;
    c[1] = 32'd4;
    queue_push(16'h0005, c);
    queue_push(16'hAAAA, flat(32'hFFFF_FFFF));
    queue_push(16'h5555, flat(32'h0000_0000));
    queue_readout();
    set_regs(4'd8, 4'd8);
    queue_push(16'h0010, flat(32'd9));
    queue_push(16'h0011, flat(32'd3));
    queue_readout();

    // random phases under several settings, extremes among them
    set_regs(4'd8, 4'd8);
    queue_random(8, 8);
    set_regs(4'd1, 4'd1);
    queue_random(6, 8);
    set_regs(4'd0, 4'd0);
    queue_random(4, 15);
    set_regs(4'd15, 4'd15);
    queue_random(4, 10);
    set_regs(4'd2, 4'd5);
    queue_random(10, 8);
    set_regs(4'd3, 4'd4);
    queue_random(8, 8);

    // candidate store fill: k above dims makes every point a candidate
    set_regs(4'd2, 4'd1);
    for (int n = 0; n < 68; n++) begin
      c = flat($urandom);
      c[0] = 32'h8000_0000;
      queue_push(kds_pkg::ID_W'($urandom), c);
    end
    queue_readout();

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/kds_pkg.sv
src/kds_ram.sv
src/kds_datapath.sv
src/kds_ctrl.sv
src/k_dominant_skyline_filter.sv
verif/k_dominant_skyline_filter_test.sv
